@@ rtl/tfd_pkg.sv @@
// shared types and constants for the thermal frame deframer
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package tfd_pkg;

  // result codes
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  // token codes from the front to the back
  typedef enum logic {
    TOK_DATA  = 1'b0,
    TOK_MAGIC = 1'b1
  } tok_cmd_t;

  typedef struct packed {
    tok_cmd_t   cmd;
    logic [7:0] data;
  } token_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  gray;
    logic [7:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [15:0] max_raw;
    logic        last;
  } result_t;

  localparam logic [23:0] MAGIC_LOW3 = 24'h00BEEF;
  localparam logic [7:0]  MAGIC_LAST = 8'h00;
  localparam int          FRAME_OPEN_BYTES = 4;
  localparam int          SIZE_FIRST_BYTE = 8;
  localparam int          SIZE_LAST_BYTE = 11;
  localparam int          HDR_BYTES = 32;
  localparam int          SIZE_EXTRA = 28;

endpackage

@@ rtl/tfd_front.sv @@
// front end: takes stream words, runs the chunk-start magic check, pushes tokens
// depends on tfd_pkg
`timescale 1ns / 1ps

module tfd_front
  import tfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       chunk_start,
  input  logic       tok_full,
  output logic       tok_push,
  output token_t     tok_data
);

  logic [23:0] magic_hold;
  logic [23:0] magic_hold_next;
  logic [1:0]  hold_count;
  logic [1:0]  hold_count_next;
  logic        magic_hit;

  always_comb begin
    in_stall = tok_full;
    tok_push = in_valid && !tok_full;
    magic_hit = (hold_count == 2'd3) && !chunk_start &&
                (magic_hold == MAGIC_LOW3) && (data_byte == MAGIC_LAST);
    tok_data.cmd = magic_hit ? TOK_MAGIC : TOK_DATA;
    tok_data.data = data_byte;

    magic_hold_next = magic_hold;
    hold_count_next = hold_count;
    if (chunk_start) begin
      magic_hold_next = {16'h0000, data_byte};
      hold_count_next = 2'd1;
    end else begin
      case (hold_count)
        2'd1: begin
          magic_hold_next[15:8] = data_byte;
          hold_count_next = 2'd2;
        end
        2'd2: begin
          magic_hold_next[23:16] = data_byte;
          hold_count_next = 2'd3;
        end
        2'd3: hold_count_next = 2'd0;
        default: hold_count_next = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_hold <= 24'h000000;
      hold_count <= 2'd0;
    end else if (tok_push) begin
      magic_hold <= magic_hold_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

@@ rtl/tfd_token_fifo.sv @@
// short token queue between front and back
// depends on tfd_pkg
`timescale 1ns / 1ps

module tfd_token_fifo
  import tfd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output token_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  token_t        entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    full = (count == CW'(DEPTH));
    valid = (count != '0);
    pop_data = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  property p_no_push_full;
    @(posedge clk) disable iff (rst) full |-> !push;
  endproperty
  a_no_push_full: assert property (p_no_push_full)
    else $error("token pushed into full queue");

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) pop |-> valid;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty)
    else $error("token popped from empty queue");

  property p_count_range;
    @(posedge clk) disable iff (rst) count <= CW'(DEPTH);
  endproperty
  a_count_range: assert property (p_count_range)
    else $error("token queue count out of range");

endmodule

@@ rtl/tfd_back.sv @@
// back end: frame tracking, pixel unpacking, completion test and result queue
// depends on tfd_pkg
`timescale 1ns / 1ps

module tfd_back
  import tfd_pkg::*;
#(
  parameter int FRAME_WIDTH = 160,
  parameter int FRAME_HEIGHT = 120,
  parameter int LINE_WORDS = 164,
  parameter int MAX_FRAME_BYTES = 1048576
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    tok_valid,
  input  token_t  tok_data,
  output logic    tok_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  localparam int BCW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LWW = $clog2(LINE_WORDS);
  localparam int ROWW = $clog2(FRAME_HEIGHT + 1);
  localparam int HALF = FRAME_WIDTH / 2;
  localparam int RQ_DEPTH = 4;
  localparam int RQPW = $clog2(RQ_DEPTH);
  localparam int RQCW = $clog2(RQ_DEPTH + 1);

  // frame state
  logic             in_frame;
  logic             in_frame_next;
  logic [BCW-1:0]   byte_count;
  logic [BCW-1:0]   byte_count_next;
  logic [31:0]      frame_size;
  logic [31:0]      frame_size_next;
  logic [7:0]       low_byte;
  logic [7:0]       low_byte_next;
  logic [15:0]      max_value;
  logic [15:0]      max_value_next;
  logic [LWW-1:0]   line_word;
  logic [LWW-1:0]   line_word_next;
  logic [ROWW-1:0]  row;
  logic [ROWW-1:0]  row_next;

  // result queue
  result_t          rq [RQ_DEPTH];
  logic [RQPW-1:0]  rq_wr;
  logic [RQPW-1:0]  rq_rd;
  logic [RQCW-1:0]  rq_count;
  logic             rq_pop;

  logic             res_a_valid;
  result_t          res_a;
  logic             res_b_valid;
  result_t          res_b;
  logic [BCW-1:0]   count_inc;
  logic [31:0]      lw_wide;
  logic             pix_ok;
  logic [7:0]       pix_x;
  logic [15:0]      raw;
  logic             done_hit;

  always_comb begin
    tok_pop = tok_valid && (rq_count <= RQCW'(RQ_DEPTH - 2));
    out_valid = (rq_count != '0);
    rq_pop = out_valid && !out_stall;
    out_data = rq[rq_rd];

    in_frame_next = in_frame;
    byte_count_next = byte_count;
    frame_size_next = frame_size;
    low_byte_next = low_byte;
    max_value_next = max_value;
    line_word_next = line_word;
    row_next = row;

    res_a_valid = 1'b0;
    res_a = '0;
    res_b_valid = 1'b0;
    res_b = '0;

    count_inc = byte_count + BCW'(1);
    lw_wide = 32'(line_word);
    raw = {tok_data.data, low_byte};
    pix_ok = 1'b0;
    pix_x = 8'h00;
    done_hit = 1'b0;

    // left half, gap words, right half
    if (lw_wide < 32'(HALF)) begin
      pix_ok = 1'b1;
      pix_x = 8'(lw_wide);
    end else if ((lw_wide >= 32'(HALF + 2)) && (lw_wide < 32'(FRAME_WIDTH + 2))) begin
      pix_ok = 1'b1;
      pix_x = 8'(lw_wide - 32'd2);
    end

    if (tok_data.cmd == TOK_MAGIC) begin
      if (in_frame) begin
        res_a_valid = 1'b1;
        res_a.kind = KIND_DROP;
        res_a.max_raw = max_value;
      end
      in_frame_next = 1'b1;
      byte_count_next = BCW'(FRAME_OPEN_BYTES);
      frame_size_next = 32'h0;
      max_value_next = 16'h0000;
      low_byte_next = 8'h00;
      line_word_next = '0;
      row_next = '0;
    end else if (in_frame) begin
      // size word, little endian
      if ((byte_count >= BCW'(SIZE_FIRST_BYTE)) && (byte_count <= BCW'(SIZE_LAST_BYTE))) begin
        case (byte_count[1:0])
          2'd0: frame_size_next[7:0] = tok_data.data;
          2'd1: frame_size_next[15:8] = tok_data.data;
          2'd2: frame_size_next[23:16] = tok_data.data;
          default: frame_size_next[31:24] = tok_data.data;
        endcase
      end
      if (byte_count >= BCW'(HDR_BYTES)) begin
        if (!byte_count[0]) begin
          low_byte_next = tok_data.data;
        end else begin
          if (line_word == LWW'(LINE_WORDS - 1)) begin
            line_word_next = '0;
            if (row != ROWW'(FRAME_HEIGHT)) row_next = row + ROWW'(1);
          end else begin
            line_word_next = line_word + LWW'(1);
          end
          if (pix_ok && (32'(row) < 32'(FRAME_HEIGHT))) begin
            if (raw > max_value) max_value_next = raw;
            res_a_valid = 1'b1;
            res_a.kind = KIND_PIXEL;
            res_a.gray = tok_data.data;
            res_a.pixel_x = pix_x;
            res_a.pixel_y = 7'(row);
          end
        end
      end
      byte_count_next = count_inc;
      done_hit = 33'(count_inc) >= (33'(frame_size_next) + 33'(SIZE_EXTRA));
      if (done_hit || (count_inc >= BCW'(MAX_FRAME_BYTES))) begin
        res_b_valid = 1'b1;
        res_b.kind = done_hit ? KIND_DONE : KIND_DROP;
        res_b.max_raw = max_value_next;
        in_frame_next = 1'b0;
        byte_count_next = '0;
      end
    end

    res_a.last = !res_b_valid;
    res_b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      byte_count <= '0;
      frame_size <= 32'h0;
      low_byte <= 8'h00;
      max_value <= 16'h0000;
      line_word <= '0;
      row <= '0;
      rq_wr <= '0;
      rq_rd <= '0;
      rq_count <= '0;
    end else begin
      if (tok_pop) begin
        in_frame <= in_frame_next;
        byte_count <= byte_count_next;
        frame_size <= frame_size_next;
        low_byte <= low_byte_next;
        max_value <= max_value_next;
        line_word <= line_word_next;
        row <= row_next;
      end
      if (rq_pop) rq_rd <= rq_rd + RQPW'(1);
      if (tok_pop) begin
        rq_wr <= rq_wr + RQPW'(res_a_valid) + RQPW'(res_b_valid);
      end
      rq_count <= rq_count - RQCW'(rq_pop)
                + (tok_pop ? (RQCW'(res_a_valid) + RQCW'(res_b_valid)) : '0);
    end
  end

  // queue entries carry no reset
  always_ff @(posedge clk) begin
    if (tok_pop) begin
      if (res_a_valid) begin
        rq[rq_wr] <= res_a;
        if (res_b_valid) rq[rq_wr + RQPW'(1)] <= res_b;
      end else if (res_b_valid) begin
        rq[rq_wr] <= res_b;
      end
    end
  end

  property p_rq_bound;
    @(posedge clk) disable iff (rst) rq_count <= RQCW'(RQ_DEPTH);
  endproperty
  a_rq_bound: assert property (p_rq_bound)
    else $error("result queue overflow");

  property p_frame_closes;
    @(posedge clk) disable iff (rst) (tok_pop && res_b_valid) |=> !in_frame;
  endproperty
  a_frame_closes: assert property (p_frame_closes)
    else $error("frame still open after frame result");

  property p_magic_opens;
    @(posedge clk) disable iff (rst)
      (tok_pop && (tok_data.cmd == TOK_MAGIC)) |=>
        (in_frame && (byte_count == BCW'(FRAME_OPEN_BYTES)));
  endproperty
  a_magic_opens: assert property (p_magic_opens)
    else $error("magic word did not open a frame");

  property p_count_limit;
    @(posedge clk) disable iff (rst) byte_count < BCW'(MAX_FRAME_BYTES);
  endproperty
  a_count_limit: assert property (p_count_limit)
    else $error("byte count reached limit with frame open");

endmodule

@@ rtl/thermal_frame_deframer_top.sv @@
// top level of the thermal frame deframer
// instantiates tfd_front, tfd_token_fifo and tfd_back; depends on tfd_pkg
`timescale 1ns / 1ps

// Thermal camera frame deframer. Takes the USB bulk stream one byte per
// cycle while in_stall is low, with chunk_start high on the first byte of each
// transfer chunk, and turns it into pixel results (gray = high byte, with
// column and row) and frame results (done or dropped, carrying the largest raw
// pixel seen). A chunk opening with EF BE 00 00 starts a frame; bytes outside a
// frame give nothing. Throughput is one byte per cycle when nothing stalls: the
// front checks the magic on the fly and the back takes a byte while its result
// queue holds at most two words. A byte gives at most two results; they pass
// through a four-entry result queue that drains one word per cycle while
// out_stall is low, so out_stall only reaches in_stall once that queue holds
// three words and the two-entry byte queue fills. Reset needs no clearing pass.

module thermal_frame_deframer_top
  import tfd_pkg::*;
#(
  parameter int FRAME_WIDTH = 160,
  parameter int FRAME_HEIGHT = 120,
  parameter int LINE_WORDS = 164,
  parameter int MAX_FRAME_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        chunk_start,
  // results out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  gray,
  output logic [7:0]  pixel_x,
  output logic [6:0]  pixel_y,
  output logic [15:0] max_raw,
  output logic        last
);

  // tokens between front and back
  logic    tok_push;
  token_t  tok_in;
  logic    tok_full;
  logic    tok_pop;
  logic    tok_valid;
  token_t  tok_out;
  result_t res;

  // magic detection, one token per accepted word
  tfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .chunk_start (chunk_start),
    .tok_full    (tok_full),
    .tok_push    (tok_push),
    .tok_data    (tok_in)
  );

  // decouples the front from back-pressure in the back
  tfd_token_fifo #(
    .DEPTH (2)
  ) u_tok_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (tok_push),
    .push_data (tok_in),
    .full      (tok_full),
    .pop       (tok_pop),
    .valid     (tok_valid),
    .pop_data  (tok_out)
  );

  // frame engine and result queue
  tfd_back #(
    .FRAME_WIDTH     (FRAME_WIDTH),
    .FRAME_HEIGHT    (FRAME_HEIGHT),
    .LINE_WORDS      (LINE_WORDS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_data  (tok_out),
    .tok_pop   (tok_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res)
  );

  // unpack the result word onto its ports
  assign kind    = res.kind;
  assign gray    = res.gray;
  assign pixel_x = res.pixel_x;
  assign pixel_y = res.pixel_y;
  assign max_raw = res.max_raw;
  assign last    = res.last;

endmodule
